// ===== sv/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Shared item types, record kinds, scan modes and default sizes.
// ----------------------------------------------------------------------------
package csvt_pkg;

   // Default width of the byte position, offset and length counters.
   localparam int POS_BITS_DEFAULT    = 31;
   // Default depth of the record-bundle queue between front and back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Width of the offset and length fields of a result item.
   localparam int OUT_BITS = 31;

   // Text characters that steer the scanner.
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;

   // Record kinds carried by a result item.
   typedef enum logic [1:0] {
      KIND_FIELD = 2'd0,
      KIND_ROW   = 2'd1,
      KIND_END   = 2'd2
   } rec_kind_type;

   // Scanner modes, one-hot.
   typedef enum logic [4:0] {
      MODE_FIELD = 5'b00001,
      MODE_UNQ   = 5'b00010,
      MODE_QUO   = 5'b00100,
      MODE_QSEEN = 5'b01000,
      MODE_CR    = 5'b10000
   } scan_mode_type;

   // Input item: one byte of text.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_item_type;

   // Result item: one record.
   typedef struct packed {
      logic [1:0]          rec_kind;
      logic [OUT_BITS-1:0] field_offset;
      logic [OUT_BITS-1:0] field_length;
   } rsp_item_type;

   // One field record inside a bundle.
   typedef struct packed {
      logic                valid;
      logic [OUT_BITS-1:0] offset;
      logic [OUT_BITS-1:0] length;
   } field_rec_type;

   // All records caused by one byte, always in this order: first field,
   // second field, row end, end of input.
   typedef struct packed {
      field_rec_type first;
      field_rec_type second;
      logic          row_end;
      logic          input_end;
   } bundle_type;

   // Queue status seen by the back part.
   typedef struct packed {
      logic       empty;
      bundle_type head;
   } queue_head_type;

endpackage

// ===== sv/csvt_front.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer front part
// Scans one byte per cycle while accept is high, updates the field state and builds the bundle
// of records that the byte causes.
// ----------------------------------------------------------------------------
module csvt_front #(
   parameter int POS_BITS = csvt_pkg::POS_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  csvt_pkg::req_item_type item,
   output logic                  bundle_push,
   output csvt_pkg::bundle_type  bundle
);
   import csvt_pkg::*;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   scan_mode_type       mode_ff, mode_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] off_ff, off_in;
   logic [POS_BITS-1:0] len_ff, len_in;
   logic                row_ff, row_in;
   logic                start;
   logic [7:0]          c;
   bundle_type          bnd;

   // Saturating add of a small step to a position-sized counter.
   function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                   input logic [1:0] b);
      logic [POS_BITS:0] sum;
      sum = {1'b0, a} + (POS_BITS + 1)'(b);
      return sum[POS_BITS] ? POS_MAX : sum[POS_BITS-1:0];
   endfunction

   assign c = item.text_byte;

   // Next state and records for the byte on the input.
   always_comb begin
      mode_in = mode_ff;
      off_in  = off_ff;
      len_in  = len_ff;
      row_in  = row_ff;
      pos_in  = sat_add(pos_ff, 2'd1);
      start   = 1'b0;
      bnd     = '0;

      unique case (mode_ff)
         MODE_UNQ: begin
            if (c == CHAR_COMMA || c == CHAR_LF || c == CHAR_CR) begin
               bnd.first.valid  = 1'b1;
               bnd.first.offset = OUT_BITS'(off_ff);
               bnd.first.length = OUT_BITS'(len_ff);
               if (c == CHAR_COMMA) begin
                  mode_in = MODE_FIELD;
               end else begin
                  bnd.row_end = 1'b1;
                  row_in      = 1'b0;
                  mode_in     = (c == CHAR_CR) ? MODE_CR : MODE_FIELD;
               end
            end else begin
               len_in = sat_add(len_ff, 2'd1);
            end
         end
         MODE_QUO: begin
            if (c == CHAR_QUOTE) begin
               mode_in = MODE_QSEEN;
            end else begin
               len_in = sat_add(len_ff, 2'd1);
            end
         end
         MODE_QSEEN: begin
            if (c == CHAR_QUOTE) begin
               // A doubled quote stays in the field as two bytes.
               len_in  = sat_add(len_ff, 2'd2);
               mode_in = MODE_QUO;
            end else begin
               bnd.first.valid  = 1'b1;
               bnd.first.offset = OUT_BITS'(off_ff);
               bnd.first.length = OUT_BITS'(len_ff);
               if (c == CHAR_COMMA) begin
                  mode_in = MODE_FIELD;
               end else begin
                  start = 1'b1;
               end
            end
         end
         MODE_CR: begin
            if (c == CHAR_LF) begin
               mode_in = MODE_FIELD;
            end else begin
               start = 1'b1;
            end
         end
         default: begin
            start = 1'b1;
         end
      endcase

      // A byte seen where a new field or row may begin.
      if (start) begin
         if (c == CHAR_LF) begin
            bnd.row_end = 1'b1;
            row_in      = 1'b0;
            mode_in     = MODE_FIELD;
         end else if (c == CHAR_CR) begin
            bnd.row_end = 1'b1;
            row_in      = 1'b0;
            mode_in     = MODE_CR;
         end else if (c == CHAR_QUOTE) begin
            row_in  = 1'b1;
            off_in  = sat_add(pos_ff, 2'd1);
            len_in  = '0;
            mode_in = MODE_QUO;
         end else if (c == CHAR_COMMA) begin
            // Only reached with no field emitted yet for this byte.
            row_in           = 1'b1;
            bnd.first.valid  = 1'b1;
            bnd.first.offset = OUT_BITS'(pos_ff);
            bnd.first.length = '0;
            mode_in          = MODE_FIELD;
         end else begin
            row_in  = 1'b1;
            off_in  = pos_ff;
            len_in  = {{(POS_BITS-1){1'b0}}, 1'b1};
            mode_in = MODE_UNQ;
         end
      end

      // Final byte: close the open field and row, mark the end and restart.
      if (item.final_byte) begin
         if (mode_in == MODE_UNQ || mode_in == MODE_QUO || mode_in == MODE_QSEEN) begin
            if (bnd.first.valid) begin
               bnd.second.valid  = 1'b1;
               bnd.second.offset = OUT_BITS'(off_in);
               bnd.second.length = OUT_BITS'(len_in);
            end else begin
               bnd.first.valid  = 1'b1;
               bnd.first.offset = OUT_BITS'(off_in);
               bnd.first.length = OUT_BITS'(len_in);
            end
            bnd.row_end = 1'b1;
         end else if (mode_in != MODE_CR && row_in) begin
            bnd.row_end = 1'b1;
         end
         bnd.input_end = 1'b1;
         mode_in       = MODE_FIELD;
         pos_in        = '0;
         off_in        = '0;
         len_in        = '0;
         row_in        = 1'b0;
      end
   end

   assign bundle      = bnd;
   assign bundle_push = accept && (bnd.first.valid || bnd.second.valid ||
                                   bnd.row_end || bnd.input_end);

   // Scanner state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FIELD;
         pos_ff  <= '0;
         off_ff  <= '0;
         len_ff  <= '0;
         row_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         off_ff  <= off_in;
         len_ff  <= len_in;
         row_ff  <= row_in;
      end
   end

endmodule

// ===== sv/csvt_queue.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer bundle queue
// Short first-in first-out queue of record bundles between front and back.
// ----------------------------------------------------------------------------
module csvt_queue #(
   parameter int DEPTH = csvt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  csvt_pkg::bundle_type     push_data,
   input  logic                     pop,
   output logic                     full,
   output csvt_pkg::queue_head_type status
);
   import csvt_pkg::*;

   localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type       store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full         = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.head  = store[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && !status.empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Bundle storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/csvt_back.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer back part
// Splits each bundle into single records and holds the oldest one in the
// output register until it is taken.
// ----------------------------------------------------------------------------
module csvt_back (
   input  logic                     clock,
   input  logic                     reset,
   input  csvt_pkg::queue_head_type status,
   output logic                     queue_pop,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output csvt_pkg::rsp_item_type   rsp_item
);
   import csvt_pkg::*;

   logic [3:0]   sent_ff, sent_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic [3:0]   parts, pending, pick;
   logic         can_load, load;

   // Records present in the head bundle, bit 0 being the oldest.
   assign parts = {status.head.input_end, status.head.row_end,
                   status.head.second.valid, status.head.first.valid};
   assign pending  = parts & ~sent_ff;
   assign pick     = pending & (~pending + 4'd1);
   assign can_load = !out_valid_ff || rsp_pop;
   assign load     = can_load && !status.empty && (pending != '0);

   // Drop the bundle once its last record is loaded.
   assign queue_pop = load && ((pending & ~pick) == '0);

   // Select the next record and update the output register.
   always_comb begin
      out_item_in  = out_item_ff;
      out_valid_in = out_valid_ff;
      sent_in      = sent_ff;

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      if (load) begin
         out_valid_in = 1'b1;
         sent_in      = queue_pop ? '0 : (sent_ff | pick);
         if (pick[0]) begin
            out_item_in.rec_kind     = KIND_FIELD;
            out_item_in.field_offset = status.head.first.offset;
            out_item_in.field_length = status.head.first.length;
         end else if (pick[1]) begin
            out_item_in.rec_kind     = KIND_FIELD;
            out_item_in.field_offset = status.head.second.offset;
            out_item_in.field_length = status.head.second.length;
         end else if (pick[2]) begin
            out_item_in.rec_kind     = KIND_ROW;
            out_item_in.field_offset = '0;
            out_item_in.field_length = '0;
         end else begin
            out_item_in.rec_kind     = KIND_END;
            out_item_in.field_offset = '0;
            out_item_in.field_length = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sent_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         sent_ff      <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ===== sv/csv_field_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Turns a stream of CSV text bytes into field, row-end and end-of-input
// records.
// ----------------------------------------------------------------------------
// Usage:
// The text enters one byte per item on the req_ side: the byte is taken at
// a clock edge with req_push high and req_full low. Mark the last byte of a
// text with final_byte; the scanner then closes any open field and row,
// adds an end-of-input record and starts afresh with the next byte.
// Records leave on the rsp_ side: the oldest waits on rsp_item while
// rsp_empty is low and is taken at an edge with rsp_pop high.
// A byte is accepted every cycle while req_full is low. The records of a
// byte pass through the bundle queue and then the single output register,
// which holds one record at a time, so sustained throughput is one byte a
// cycle while each byte gives at most one record and the receiver keeps
// popping. A queue of QUEUE_DEPTH bundles absorbs bursts; when the
// receiver stalls it fills and req_full rises until room is made.
// Reset clears the scanner state, the queue and the output register.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_top #(
   parameter int POS_BITS    = csvt_pkg::POS_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = csvt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  csvt_pkg::req_item_type req_item,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output csvt_pkg::rsp_item_type rsp_item
);
   import csvt_pkg::*;

   logic           accept;
   logic           bundle_push;
   bundle_type     bundle;
   logic           queue_pop;
   queue_head_type status;

   assign accept = req_push && !req_full;

   // Byte scanner.
   csvt_front #(
      .POS_BITS(POS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .item        (req_item),
      .bundle_push (bundle_push),
      .bundle      (bundle)
   );

   // Bundle queue between scanner and record output.
   csvt_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (bundle_push),
      .push_data (bundle),
      .pop       (queue_pop),
      .full      (req_full),
      .status    (status)
   );

   // Record output.
   csvt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .queue_pop (queue_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== tb/csv_field_tokenizer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSV field tokenizer checker
// Watches both queue ports of the tokenizer. Every accepted text byte is run
// through a scanner model of its own, which queues the records that byte
// should give; every record taken from the block is compared, field by
// field, with the oldest queued record.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_checker #(
   parameter int POS_W = csvt_pkg::POS_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  csvt_pkg::req_item_type req_item,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  csvt_pkg::rsp_item_type rsp_item,
   output int                     fail_count,
   output int                     records_pending
);

   import csvt_pkg::*;

   // One byte never gives more records than this.
   localparam int MAX_RECORDS_PER_BYTE = 4;
   // Only this many mismatches are printed in full.
   localparam int REPORT_LIMIT = 10;

   // Scanner model state.
   scan_mode_type    scan_state;
   logic [POS_W-1:0] byte_pos;
   logic [POS_W-1:0] open_offset;
   logic [POS_W-1:0] open_length;
   logic             row_open;
   int               records_this_byte;

   // Records still owed by the block, oldest first.
   rsp_item_type     expected_records[$];

   initial begin
      fail_count      = 0;
      records_pending = 0;
   end

   // Counters stick at their largest value instead of wrapping.
   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] a,
                                                input logic [1:0] b);
      logic [POS_W:0] sum;
      sum = {1'b0, a} + (POS_W + 1)'(b);
      return sum[POS_W] ? '1 : sum[POS_W-1:0];
   endfunction

   task automatic clear_scanner();
      scan_state  = MODE_FIELD;
      byte_pos    = '0;
      open_offset = '0;
      open_length = '0;
      row_open    = 1'b0;
   endtask

   // Queue one record, dropping any beyond the per-byte maximum.
   task automatic add_record(input rec_kind_type kind, input logic [POS_W-1:0] off,
                             input logic [POS_W-1:0] len);
      rsp_item_type rec;
      if (records_this_byte < MAX_RECORDS_PER_BYTE) begin
         rec.rec_kind     = kind;
         rec.field_offset = off[OUT_BITS-1:0];
         rec.field_length = len[OUT_BITS-1:0];
         expected_records.push_back(rec);
         records_this_byte++;
      end
   endtask

   task automatic close_row();
      add_record(KIND_ROW, '0, '0);
      row_open = 1'b0;
   endtask

   // A byte seen where a new field or a new row may begin.
   task automatic begin_field(input logic [7:0] c, input logic [POS_W-1:0] pos);
      if (c == CHAR_LF) begin
         close_row();
         scan_state = MODE_FIELD;
      end else if (c == CHAR_CR) begin
         close_row();
         scan_state = MODE_CR;
      end else if (c == CHAR_QUOTE) begin
         row_open    = 1'b1;
         open_offset = sat_inc(pos, 2'd1);
         open_length = '0;
         scan_state  = MODE_QUO;
      end else if (c == CHAR_COMMA) begin
         // A comma where a field may begin: an empty field at this comma.
         row_open   = 1'b1;
         add_record(KIND_FIELD, pos, '0);
         scan_state = MODE_FIELD;
      end else begin
         row_open    = 1'b1;
         open_offset = pos;
         open_length = POS_W'(1);
         scan_state  = MODE_UNQ;
      end
   endtask

   // Advance the scanner model by one text byte.
   task automatic scan_byte(input logic [7:0] c, input logic last);
      logic [POS_W-1:0] pos;
      pos = byte_pos;
      records_this_byte = 0;
      case (scan_state)
         MODE_UNQ: begin
            if (c == CHAR_COMMA || c == CHAR_LF || c == CHAR_CR) begin
               add_record(KIND_FIELD, open_offset, open_length);
               if (c == CHAR_COMMA) begin
                  scan_state = MODE_FIELD;
               end else begin
                  close_row();
                  scan_state = (c == CHAR_CR) ? MODE_CR : MODE_FIELD;
               end
            end else begin
               open_length = sat_inc(open_length, 2'd1);
            end
         end
         MODE_QUO: begin
            if (c == CHAR_QUOTE) begin
               scan_state = MODE_QSEEN;
            end else begin
               open_length = sat_inc(open_length, 2'd1);
            end
         end
         MODE_QSEEN: begin
            // A doubled quote stays in the field as two bytes.
            if (c == CHAR_QUOTE) begin
               open_length = sat_inc(open_length, 2'd2);
               scan_state  = MODE_QUO;
            end else begin
               add_record(KIND_FIELD, open_offset, open_length);
               if (c == CHAR_COMMA) begin
                  scan_state = MODE_FIELD;
               end else begin
                  begin_field(c, pos);
               end
            end
         end
         MODE_CR: begin
            if (c == CHAR_LF) begin
               scan_state = MODE_FIELD;
            end else begin
               begin_field(c, pos);
            end
         end
         default: begin
            begin_field(c, pos);
         end
      endcase

      byte_pos = sat_inc(byte_pos, 2'd1);

      // The last byte closes what is open and marks the end of the text.
      if (last) begin
         if (scan_state == MODE_UNQ || scan_state == MODE_QUO ||
             scan_state == MODE_QSEEN) begin
            add_record(KIND_FIELD, open_offset, open_length);
            close_row();
         end else if (scan_state != MODE_CR && row_open) begin
            close_row();
         end
         add_record(KIND_END, '0, '0);
         clear_scanner();
      end
   endtask

   // Compare taken records first, then predict from the accepted byte.
   always @(posedge clock) begin
      if (reset) begin
         clear_scanner();
         expected_records.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_records.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("unexpected record: kind %0d offset %0d length %0d",
                           rsp_item.rec_kind, rsp_item.field_offset,
                           rsp_item.field_length);
               end
            end else begin
               if (rsp_item.rec_kind != expected_records[0].rec_kind ||
                   rsp_item.field_offset != expected_records[0].field_offset ||
                   rsp_item.field_length != expected_records[0].field_length) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     // Values are printed as kind, offset and length.
                     $display("record mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                              expected_records[0].rec_kind,
                              expected_records[0].field_offset,
                              expected_records[0].field_length,
                              rsp_item.rec_kind, rsp_item.field_offset,
                              rsp_item.field_length);
                  end
               end
               void'(expected_records.pop_front());
            end
         end
         if (req_push && !req_full) begin
            scan_byte(req_item.text_byte, req_item.final_byte);
         end
      end
      records_pending = expected_records.size();
   end

endmodule

// ===== tb/csv_field_tokenizer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// Feeds the tokenizer with a short run of hand-picked text covering quoting,
// separators, line ends and end-of-text handling, then with random CSV texts,
// some broken and some pure noise. Both ports idle at random; the receiver
// holds off long enough once to fill the block. A checker module beside the
// block predicts and compares every record.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_top_tb;

   import csvt_pkg::*;

   // Run length and idling shape.
   localparam int TOTAL_ITEMS      = 330;
   localparam int HOLD_AFTER_ITEMS = 120;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int DRAIN_LIMIT      = 5000;
   localparam int SETTLE_CYCLES    = 16;

   logic         clock;
   logic         reset;
   logic         req_push;
   logic         req_full;
   req_item_type req_item;
   logic         rsp_empty;
   logic         rsp_pop;
   rsp_item_type rsp_item;

   int           check_failures;
   int           records_pending;
   int           items_sent;
   bit           quiet_phase;
   logic [7:0]   text_bytes[$];

   csv_field_tokenizer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   csv_field_tokenizer_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_item        (req_item),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_item        (rsp_item),
      .fail_count      (check_failures),
      .records_pending (records_pending)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 2))
         0:       return CHAR_COMMA;
         1:       return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // Any byte that the scanner treats as plain text.
   task automatic add_plain_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == CHAR_QUOTE || b == CHAR_COMMA || b == CHAR_CR || b == CHAR_LF);
      text_bytes.push_back(b);
   endtask

   // Offer one text byte at a falling edge and wait until it is taken.
   // The push stays high on return, so a following item can come at once.
   task automatic send_byte(input logic [7:0] value, input logic last);
      int           gap;
      req_item_type next_item;
      gap = idle_length();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      next_item.text_byte  = value;
      next_item.final_byte = last;
      req_item <= next_item;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Build a well-formed text of one to three rows.
   task automatic build_csv_text();
      int rows;
      int fields;
      int len;
      int ending;
      rows = $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
         fields = $urandom_range(1, 4);
         for (int f = 0; f < fields; f++) begin
            if (f > 0) text_bytes.push_back(CHAR_COMMA);
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 9) < 6) begin
               for (int k = 0; k < len; k++) add_plain_byte();
            end else begin
               // Quoted content may hold doubled quotes and separators.
               text_bytes.push_back(CHAR_QUOTE);
               for (int k = 0; k < len; k++) begin
                  case ($urandom_range(0, 9))
                     0, 1: begin
                        text_bytes.push_back(CHAR_QUOTE);
                        text_bytes.push_back(CHAR_QUOTE);
                     end
                     2, 3:    text_bytes.push_back(pick_separator());
                     default: add_plain_byte();
                  endcase
               end
               text_bytes.push_back(CHAR_QUOTE);
            end
         end
         // A trailing comma now and then, just before the line end.
         if ($urandom_range(0, 9) == 0) text_bytes.push_back(CHAR_COMMA);
         ending = $urandom_range(0, 3);
         if (ending == 3 && r < rows - 1) ending = 0;
         case (ending)
            0: text_bytes.push_back(CHAR_LF);
            1: begin
               text_bytes.push_back(CHAR_CR);
               text_bytes.push_back(CHAR_LF);
            end
            2: text_bytes.push_back(CHAR_CR);
            default: ;
         endcase
      end
   endtask

   // Receiver: pops with random stalls, and once holds off for a long
   // stretch while the sender keeps going, so that the block fills up.
   initial begin : receiver
      int stall;
      bit hold_done;
      stall     = 0;
      hold_done = 1'b0;
      rsp_pop   = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!hold_done && items_sent >= HOLD_AFTER_ITEMS) begin
            hold_done = 1'b1;
            stall     = LONG_HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
            stall = idle_length();
         end
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      int text_count;
      int choice;
      int keep;
      int drain_cycles;
      reset       = 1'b1;
      req_push    = 1'b0;
      req_item    = '0;
      items_sent  = 0;
      quiet_phase = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Extreme bytes, an empty field between commas, a comma before a line end.
      send_byte(8'h00, 1'b0);
      send_byte(CHAR_COMMA, 1'b0);
      send_byte(CHAR_COMMA, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(CHAR_COMMA, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      // A doubled quote, text after a closing quote, a comma after one, CR LF.
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte("z", 1'b0);
      send_byte(CHAR_COMMA, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte("q", 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_COMMA, 1'b0);
      send_byte(CHAR_CR, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      // Empty row on a bare CR, a bare LF after a field, another empty row.
      send_byte(CHAR_CR, 1'b0);
      send_byte("A", 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      // A quote left open until the last byte.
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte("u", 1'b1);
      // A closing quote that arrives as the last byte.
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_QUOTE, 1'b1);

      // Let the block drain completely before the random part.
      req_push <= 1'b0;
      do @(negedge clock); while (records_pending != 0);

      // Random texts: mostly well-formed, some cut short, some pure noise.
      text_count = 0;
      while (items_sent < TOTAL_ITEMS) begin
         quiet_phase = (text_count >= 10 && text_count < 18);
         text_bytes.delete();
         choice = $urandom_range(0, 99);
         if (choice < 15) begin
            repeat ($urandom_range(1, 10)) begin
               if ($urandom_range(0, 1) == 0) begin
                  text_bytes.push_back(pick_separator());
               end else if ($urandom_range(0, 2) == 0) begin
                  text_bytes.push_back(CHAR_QUOTE);
               end else begin
                  text_bytes.push_back(8'($urandom_range(0, 255)));
               end
            end
         end else begin
            build_csv_text();
            if (choice < 30) begin
               keep = $urandom_range(1, text_bytes.size());
               while (text_bytes.size() > keep) void'(text_bytes.pop_back());
            end
         end
         for (int i = 0; i < text_bytes.size(); i++) begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
         end
         text_count++;
      end
      quiet_phase = 1'b0;

      // Wait for every owed record, then a little longer for strays.
      req_push <= 1'b0;
      drain_cycles = 0;
      do begin
         @(negedge clock);
         drain_cycles++;
      end while (records_pending != 0 && drain_cycles < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (check_failures == 0 && records_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
